// ===== sv/qfr_pkg.sv =====
package qfr_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DATA_W    = 16;
   localparam int NUM_W     = DATA_W + 1;
   localparam int RAD_W     = 30;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int DIV_STEPS = 16;
   localparam int THR_W     = 15;
   localparam int PATH_W    = 2;

   localparam logic [PATH_W-1:0] PATH_TRACE = 2'd0;
   localparam logic [PATH_W-1:0] PATH_X     = 2'd1;
   localparam logic [PATH_W-1:0] PATH_Y     = 2'd2;
   localparam logic [PATH_W-1:0] PATH_Z     = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] q_w;
      logic signed [DATA_W-1:0] q_x;
      logic signed [DATA_W-1:0] q_y;
      logic signed [DATA_W-1:0] q_z;
      logic [PATH_W-1:0]        path_used;
   } rsp_type;

   // Numerators and axis choice that ride alongside the square roots.
   typedef struct packed {
      logic [PATH_W-1:0]       axis;
      logic signed [NUM_W-1:0] tr_x;
      logic signed [NUM_W-1:0] tr_y;
      logic signed [NUM_W-1:0] tr_z;
      logic signed [NUM_W-1:0] dg_x;
      logic signed [NUM_W-1:0] dg_y;
      logic signed [NUM_W-1:0] dg_z;
   } prep_side_type;

   // What rides alongside the dividers.
   typedef struct packed {
      logic [ROOT_W-1:0] w;
      logic [ROOT_W-1:0] comp;
      logic [PATH_W-1:0] path;
   } div_side_type;

endpackage

// ===== sv/quaternion_from_rotation_matrix.sv =====
// A matrix reaches rsp_valid via the prep, sqrt, select, divider and output registers.
// Throughput: one matrix per cycle; busy stays low since results cannot be stalled.
// The depth is set by the 15-stage square root followed by the 18-stage divider.
// Reset (synchronous, active high) empties the pipeline and sets w_threshold to 1.
module quaternion_from_rotation_matrix
   import qfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   localparam int SQRT_LAT = ROOT_W;
   localparam int DIV_LAT  = DIV_STEPS + 2;

   // The threshold register. Writes are expected only while the pipeline is empty,
   // so every transfer is taken at once.
   logic [THR_W-1:0] w_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_thr_ff <= THR_W'(1);
      end else if (csr_valid && csr_ready) begin
         w_thr_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // Stage one: trace, largest diagonal, radicands and all candidate numerators.
   logic             prep_valid;
   logic [RAD_W-1:0] rad_w, rad_c;
   prep_side_type    prep_side;

   qfr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .rad_w     (rad_w),
      .rad_c     (rad_c),
      .side      (prep_side)
   );

   // Both square roots run in parallel: w from the trace and the diagonal
   // component, which is only used when the trace path is rejected.
   logic              root_valid, root_c_valid;
   logic [ROOT_W-1:0] root_w, root_c;

   qfr_sqrt u_sqrt_w (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .rad       (rad_w),
      .out_valid (root_valid),
      .root      (root_w)
   );

   qfr_sqrt u_sqrt_c (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .rad       (rad_c),
      .out_valid (root_c_valid),
      .root      (root_c)
   );

   // The numerators wait in a delay line matched to the square-root depth.
   prep_side_type side_dly_ff [SQRT_LAT];

   always_ff @(posedge clock) begin
      side_dly_ff[0] <= prep_side;
      for (int i = 1; i < SQRT_LAT; i++) begin
         side_dly_ff[i] <= side_dly_ff[i-1];
      end
   end

   // Path select stage. The trace path wins when w is above the threshold;
   // otherwise each lane divides by the diagonal component, and the lane of
   // the chosen axis gets a zero numerator and is replaced at the output.
   prep_side_type           sel_side;
   logic                    use_trace;
   logic                    sel_valid_ff;
   logic [ROOT_W-1:0]       den_ff, den_in;
   logic signed [NUM_W-1:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   div_side_type            dside_ff, dside_in;

   always_comb begin
      sel_side  = side_dly_ff[SQRT_LAT-1];
      use_trace = (root_w > w_thr_ff);
      den_in    = use_trace ? root_w : root_c;
      nx_in     = use_trace ? sel_side.tr_x : sel_side.dg_x;
      ny_in     = use_trace ? sel_side.tr_y : sel_side.dg_y;
      nz_in     = use_trace ? sel_side.tr_z : sel_side.dg_z;
      dside_in.w    = root_w;
      dside_in.comp = root_c;
      dside_in.path = use_trace ? PATH_TRACE : sel_side.axis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= root_valid && root_c_valid;
      end
      den_ff   <= den_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      nz_ff    <= nz_in;
      dside_ff <= dside_in;
   end

   // Three divider lanes, one per vector component.
   logic                     qx_valid, qy_valid, qz_valid;
   logic signed [DATA_W-1:0] qx, qy, qz;

   qfr_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid_ff),
      .num       (nx_ff),
      .den       (den_ff),
      .out_valid (qx_valid),
      .quo       (qx)
   );

   qfr_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid_ff),
      .num       (ny_ff),
      .den       (den_ff),
      .out_valid (qy_valid),
      .quo       (qy)
   );

   qfr_div u_div_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid_ff),
      .num       (nz_ff),
      .den       (den_ff),
      .out_valid (qz_valid),
      .quo       (qz)
   );

   div_side_type dside_dly_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      dside_dly_ff[0] <= dside_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         dside_dly_ff[i] <= dside_dly_ff[i-1];
      end
   end

   // Output register: w is always the trace root, and on a diagonal path the
   // chosen axis shows its own square root instead of a quotient.
   div_side_type out_side;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff, rsp_data_in;

   always_comb begin
      out_side              = dside_dly_ff[DIV_LAT-1];
      rsp_data_in.q_w       = DATA_W'(out_side.w);
      rsp_data_in.q_x       = (out_side.path == PATH_X) ? DATA_W'(out_side.comp) : qx;
      rsp_data_in.q_y       = (out_side.path == PATH_Y) ? DATA_W'(out_side.comp) : qy;
      rsp_data_in.q_z       = (out_side.path == PATH_Z) ? DATA_W'(out_side.comp) : qz;
      rsp_data_in.path_used = out_side.path;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= qx_valid && qy_valid && qz_valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/qfr_prep.sv =====
module qfr_prep
   import qfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  req_type       in_data,
   output logic          out_valid,
   output logic [RAD_W-1:0] rad_w,
   output logic [RAD_W-1:0] rad_c,
   output prep_side_type side
);

   localparam logic signed [NUM_W+1:0] ONE_R = (NUM_W+2)'(1) <<< FRAC_BITS;
   localparam logic signed [NUM_W-1:0] ONE_D = (NUM_W)'(1) <<< FRAC_BITS;

   logic                    valid_ff;
   logic [RAD_W-1:0]        rad_w_ff, rad_w_in;
   logic [RAD_W-1:0]        rad_c_ff, rad_c_in;
   prep_side_type           side_ff, side_in;
   logic signed [NUM_W+1:0] r_sum;
   logic signed [NUM_W-1:0] d_sum;
   logic signed [DATA_W-1:0] diag;
   logic [PATH_W-1:0]       axis;
   logic signed [NUM_W-1:0] s01, s02, s12;

   always_comb begin
      r_sum = (NUM_W+2)'(in_data.m00) + (NUM_W+2)'(in_data.m11)
            + (NUM_W+2)'(in_data.m22) + ONE_R;
      rad_w_in = r_sum[NUM_W+1] ? '0 : (RAD_W'(r_sum[NUM_W:0]) << (FRAC_BITS - 2));

      // Later axis wins a tie between x and y; z needs a strict win.
      if (in_data.m00 > in_data.m11) begin
         axis = PATH_X;
         diag = in_data.m00;
      end else begin
         axis = PATH_Y;
         diag = in_data.m11;
      end
      if (in_data.m22 > diag) begin
         axis = PATH_Z;
         diag = in_data.m22;
      end
      d_sum = NUM_W'(diag) + ONE_D;
      rad_c_in = d_sum[NUM_W-1] ? '0 : (RAD_W'(d_sum[NUM_W-2:0]) << (FRAC_BITS - 1));

      s01 = NUM_W'(in_data.m01) + NUM_W'(in_data.m10);
      s02 = NUM_W'(in_data.m02) + NUM_W'(in_data.m20);
      s12 = NUM_W'(in_data.m12) + NUM_W'(in_data.m21);

      side_in.axis = axis;
      side_in.tr_x = NUM_W'(in_data.m21) - NUM_W'(in_data.m12);
      side_in.tr_y = NUM_W'(in_data.m02) - NUM_W'(in_data.m20);
      side_in.tr_z = NUM_W'(in_data.m10) - NUM_W'(in_data.m01);
      side_in.dg_x = (axis == PATH_Y) ? s01 : ((axis == PATH_Z) ? s02 : '0);
      side_in.dg_y = (axis == PATH_X) ? s01 : ((axis == PATH_Z) ? s12 : '0);
      side_in.dg_z = (axis == PATH_X) ? s02 : ((axis == PATH_Y) ? s12 : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rad_w_ff <= rad_w_in;
      rad_c_ff <= rad_c_in;
      side_ff  <= side_in;
   end

   assign out_valid = valid_ff;
   assign rad_w     = rad_w_ff;
   assign rad_c     = rad_c_ff;
   assign side      = side_ff;

endmodule

// ===== sv/qfr_sqrt.sv =====
module qfr_sqrt
   import qfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  rad,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root
);

   // One result bit per stage, two radicand bits consumed per stage.
   logic              val_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [ROOT_W+1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              p_val;
      logic [RAD_W-1:0]  p_rad;
      logic [ROOT_W+1:0] p_rem;
      logic [ROOT_W-1:0] p_root;
      logic [ROOT_W+3:0] trial_num;
      logic [ROOT_W+3:0] trial_sub;
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign p_val  = in_valid;
         assign p_rad  = rad;
         assign p_rem  = '0;
         assign p_root = '0;
      end else begin : g_next
         assign p_val  = val_ff[s-1];
         assign p_rad  = rad_ff[s-1];
         assign p_rem  = rem_ff[s-1];
         assign p_root = root_ff[s-1];
      end

      always_comb begin
         trial_num = {p_rem, p_rad[RAD_W-1:RAD_W-2]};
         trial_sub = {2'b00, p_root, 2'b01};
         if (trial_num >= trial_sub) begin
            rem_in  = (ROOT_W+2)'(trial_num - trial_sub);
            root_in = {p_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = (ROOT_W+2)'(trial_num);
            root_in = {p_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else begin
            val_ff[s] <= p_val;
         end
         rad_ff[s]  <= p_rad << 2;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign out_valid = val_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];

endmodule

// ===== sv/qfr_div.sv =====
module qfr_div
   import qfr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0]        den,
   output logic                     out_valid,
   output logic signed [DATA_W-1:0] quo
);

   // Computes num * 2^FRAC_BITS / (4 den), truncated toward zero and saturated.
   localparam int SHIFT = FRAC_BITS - 2;

   logic              val_ff  [DIV_STEPS+1];
   logic              neg_ff  [DIV_STEPS+1];
   logic              zero_ff [DIV_STEPS+1];
   logic              ovf_ff  [DIV_STEPS+1];
   logic [ROOT_W-1:0] den_ff  [DIV_STEPS+1];
   logic [ROOT_W-1:0] rem_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] low_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff  [DIV_STEPS+1];

   logic [NUM_W-1:0]      mag;
   logic [NUM_W+SHIFT-1:0] scaled;

   always_comb begin
      mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      scaled = (NUM_W+SHIFT)'(mag) << SHIFT;
   end

   // Setup: anything at or above den * 2^16 overflows the result anyway.
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else begin
         val_ff[0] <= in_valid;
      end
      neg_ff[0]  <= num[NUM_W-1];
      zero_ff[0] <= (num == '0);
      ovf_ff[0]  <= ((NUM_W+SHIFT)'(scaled >> DIV_STEPS) >= (NUM_W+SHIFT)'(den));
      den_ff[0]  <= den;
      rem_ff[0]  <= ROOT_W'(scaled >> DIV_STEPS);
      low_ff[0]  <= scaled[DIV_STEPS-1:0];
      q_ff[0]    <= '0;
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      logic [ROOT_W:0]   part;
      logic [ROOT_W-1:0] rem_in;
      logic              bit_in;

      always_comb begin
         part = {rem_ff[s-1], low_ff[s-1][DIV_STEPS-1]};
         if (part >= {1'b0, den_ff[s-1]}) begin
            rem_in = ROOT_W'(part - {1'b0, den_ff[s-1]});
            bit_in = 1'b1;
         end else begin
            rem_in = ROOT_W'(part);
            bit_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else begin
            val_ff[s] <= val_ff[s-1];
         end
         neg_ff[s]  <= neg_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
         ovf_ff[s]  <= ovf_ff[s-1];
         den_ff[s]  <= den_ff[s-1];
         rem_ff[s]  <= rem_in;
         low_ff[s]  <= low_ff[s-1] << 1;
         q_ff[s]    <= {q_ff[s-1][DIV_STEPS-2:0], bit_in};
      end
   end

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic                     valid_ff;
   logic signed [DATA_W-1:0] quo_ff, quo_in;
   logic [DIV_STEPS-1:0]     q_fin;

   always_comb begin
      q_fin = q_ff[DIV_STEPS];
      if (zero_ff[DIV_STEPS]) begin
         quo_in = '0;
      end else if (ovf_ff[DIV_STEPS]) begin
         quo_in = neg_ff[DIV_STEPS] ? SAT_MIN : SAT_MAX;
      end else if (neg_ff[DIV_STEPS]) begin
         quo_in = (q_fin > DIV_STEPS'(SAT_MIN)) ? SAT_MIN : DATA_W'(-q_fin);
      end else begin
         quo_in = q_fin[DIV_STEPS-1] ? SAT_MAX : DATA_W'(q_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= val_ff[DIV_STEPS];
      end
      quo_ff <= quo_in;
   end

   assign out_valid = valid_ff;
   assign quo       = quo_ff;

endmodule
